// File: design/nir_pkg.sv
// Shared types and constants for the NEC IR frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nir_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 8;
   localparam int FrameBits     = 32;
   localparam int BitIndexWidth = $clog2(FrameBits);

   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_LOW_LIMIT  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_HIGH_LIMIT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BIT_LOW_LIMIT     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BIT_HIGH_LIMIT    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ONE_THRESHOLD     = 3'd4;

   localparam logic [7:0] LEADER_LOW_LIMIT_RESET  = 8'd200;
   localparam logic [7:0] LEADER_HIGH_LIMIT_RESET = 8'd80;
   localparam logic [7:0] BIT_LOW_LIMIT_RESET     = 8'd15;
   localparam logic [7:0] BIT_HIGH_LIMIT_RESET    = 8'd40;
   localparam logic [7:0] ONE_THRESHOLD_RESET     = 8'd25;

   localparam logic [8:0] COMPLEMENT_SUM = 9'h0FF;
   localparam logic [BitIndexWidth-1:0] LAST_BIT_INDEX = BitIndexWidth'(FrameBits - 1);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_LEAD_LOW  = 5'b00010,
      PH_LEAD_HIGH = 5'b00100,
      PH_BIT_LOW   = 5'b01000,
      PH_BIT_HIGH  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] leader_low_limit;
      logic [7:0] leader_high_limit;
      logic [7:0] bit_low_limit;
      logic [7:0] bit_high_limit;
      logic [7:0] one_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic [7:0] address_code;
      logic       status;
   } rsp_type;

endpackage

// File: design/nir_csr.sv
// Configuration registers of the NEC IR frame receiver.
// Depends on nir_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module nir_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [nir_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [nir_pkg::CsrDataWidth-1:0]  csr_data,
   output nir_pkg::cfg_type                  cfg
);
   import nir_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LEADER_LOW_LIMIT:  cfg_in.leader_low_limit  = csr_data;
            CSR_LEADER_HIGH_LIMIT: cfg_in.leader_high_limit = csr_data;
            CSR_BIT_LOW_LIMIT:     cfg_in.bit_low_limit     = csr_data;
            CSR_BIT_HIGH_LIMIT:    cfg_in.bit_high_limit    = csr_data;
            CSR_ONE_THRESHOLD:     cfg_in.one_threshold     = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_low_limit  <= LEADER_LOW_LIMIT_RESET;
         cfg_ff.leader_high_limit <= LEADER_HIGH_LIMIT_RESET;
         cfg_ff.bit_low_limit     <= BIT_LOW_LIMIT_RESET;
         cfg_ff.bit_high_limit    <= BIT_HIGH_LIMIT_RESET;
         cfg_ff.one_threshold     <= ONE_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/nir_decoder.sv
// Input register and frame decoder: phase, tick count, bit index and frame bits.
// Depends on nir_pkg for phase_type, cfg_type and rsp_type.
`timescale 1ns / 1ps

module nir_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_pin_level,
   input  nir_pkg::cfg_type cfg,
   input  logic             rsp_space,
   output logic             rsp_push,
   output nir_pkg::rsp_type rsp_data
);
   import nir_pkg::*;

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic                     in_level_ff;
   logic                     advance;
   logic                     lvl;

   phase_type                phase_ff;
   phase_type                phase_in;
   logic [7:0]               count_ff;
   logic [7:0]               count_in;
   logic [BitIndexWidth-1:0] index_ff;
   logic [BitIndexWidth-1:0] index_in;
   logic [FrameBits-1:0]     frame_ff;
   logic [FrameBits-1:0]     frame_in;

   logic                     fresh;
   logic [BitIndexWidth-1:0] fresh_index;
   logic [FrameBits-1:0]     fresh_frame;
   logic                     bit_exit;
   logic [8:0]               exit_count;
   logic [FrameBits-1:0]     bit_frame;
   logic                     emit;
   logic [FrameBits-1:0]     emit_frame;
   logic                     sums_ok;

   assign advance     = in_valid_ff && rsp_space;
   assign req_stall   = in_valid_ff && !rsp_space;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign lvl         = in_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_stall ? in_valid_ff : in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_level_ff <= req_pin_level;
      end
   end

   assign bit_frame = frame_ff |
      (FrameBits'(exit_count > {1'b0, cfg.one_threshold}) << index_ff);

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      frame_in    = frame_ff;
      fresh       = 1'b0;
      fresh_index = '0;
      fresh_frame = '0;
      bit_exit    = 1'b0;
      exit_count  = '0;
      emit        = 1'b0;
      emit_frame  = frame_ff;

      case (phase_ff)
         PH_LEAD_LOW: begin
            if (!lvl && count_ff < cfg.leader_low_limit) begin
               count_in = count_ff + 8'd1;
            end else if (lvl && cfg.leader_high_limit != 8'd0) begin
               phase_in = PH_LEAD_HIGH;
               count_in = 8'd1;
            end else begin
               fresh = 1'b1;
            end
         end
         PH_LEAD_HIGH: begin
            if (lvl && count_ff < cfg.leader_high_limit) begin
               count_in = count_ff + 8'd1;
            end else begin
               fresh = 1'b1;
            end
         end
         PH_BIT_LOW: begin
            if (!lvl && count_ff < cfg.bit_low_limit) begin
               count_in = count_ff + 8'd1;
            end else if (lvl) begin
               fresh       = 1'b1;
               fresh_index = index_ff;
               fresh_frame = frame_ff;
            end else begin
               bit_exit = 1'b1;
            end
         end
         PH_BIT_HIGH: begin
            if (lvl && count_ff < cfg.bit_high_limit) begin
               count_in = count_ff + 8'd1;
            end else begin
               bit_exit   = 1'b1;
               exit_count = {1'b0, count_ff} + {8'd0, lvl};
            end
         end
         default: begin
            if (lvl) begin
               phase_in = PH_IDLE;
            end else if (cfg.leader_low_limit != 8'd0) begin
               phase_in = PH_LEAD_LOW;
               count_in = 8'd1;
               index_in = '0;
               frame_in = '0;
            end else begin
               fresh = 1'b1;
            end
         end
      endcase

      if (bit_exit) begin
         if (index_ff == LAST_BIT_INDEX) begin
            emit       = 1'b1;
            emit_frame = bit_frame;
         end else begin
            fresh       = 1'b1;
            fresh_index = index_ff + 1'b1;
            fresh_frame = bit_frame;
         end
      end

      // fresh bit phase; a zero limit runs the rest of the frame in this tick
      if (fresh) begin
         if (!lvl && cfg.bit_low_limit != 8'd0) begin
            phase_in = PH_BIT_LOW;
            count_in = 8'd1;
            index_in = fresh_index;
            frame_in = fresh_frame;
         end else if (lvl && cfg.bit_high_limit != 8'd0) begin
            phase_in = PH_BIT_HIGH;
            count_in = 8'd1;
            index_in = fresh_index;
            frame_in = fresh_frame;
         end else begin
            emit       = 1'b1;
            emit_frame = fresh_frame;
            if (lvl && cfg.one_threshold == 8'd0) begin
               emit_frame = fresh_frame | ({FrameBits{1'b1}} << fresh_index);
            end
         end
      end

      if (emit) begin
         index_in = '0;
         frame_in = '0;
         if (lvl) begin
            phase_in = PH_IDLE;
            count_in = 8'd0;
         end else begin
            phase_in = PH_LEAD_LOW;
            count_in = (cfg.leader_low_limit != 8'd0) ? 8'd1 : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         index_ff <= '0;
         frame_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         index_ff <= index_in;
         frame_ff <= frame_in;
      end
   end

   assign sums_ok = ({1'b0, emit_frame[7:0]} + {1'b0, emit_frame[15:8]} == COMPLEMENT_SUM) &&
                    ({1'b0, emit_frame[23:16]} + {1'b0, emit_frame[31:24]} == COMPLEMENT_SUM);

   assign rsp_push              = advance && emit;
   assign rsp_data.key_code     = emit_frame[23:16];
   assign rsp_data.address_code = emit_frame[7:0];
   assign rsp_data.status       = !sums_ok;

endmodule

// File: design/nir_rsp_queue.sv
// Two-entry result queue between the decoder and the rsp channel.
// Depends on nir_pkg for rsp_type.
`timescale 1ns / 1ps

module nir_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nir_pkg::rsp_type push_data,
   output logic             space,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nir_pkg::rsp_type rsp_data
);
   import nir_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       pop;

   assign rsp_valid = fill_ff != 2'd0;
   assign space     = fill_ff != 2'd2;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/nec_ir_frame_receiver.sv
// Top level of the NEC IR frame receiver: config registers, decoder, result queue.
// Depends on nir_pkg, nir_csr, nir_decoder and nir_rsp_queue.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   req     | req_valid/stall    | req_pin_level (one line sample per item)
//   rsp     | rsp_valid/stall    | rsp_key_code, rsp_address_code, rsp_status
//   csr     | csr_write          | csr_index, csr_data
//
// One item per cycle unless req stalls; an accepted sample is held in the input
// register and decoded from there; a frame result is registered in the queue before rsp.
// Results sit in a two-entry queue; req stalls only when both entries are full.
// Reset is synchronous: phase idle, counters and frame bits cleared, registers
// back to their default limits.
`timescale 1ns / 1ps

module nec_ir_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_pin_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_key_code,
   output logic [7:0]                        rsp_address_code,
   output logic                              rsp_status,
   input  logic                              csr_write,
   input  logic [nir_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [nir_pkg::CsrDataWidth-1:0]  csr_data
);
   import nir_pkg::*;

   cfg_type cfg;
   logic    rsp_space;
   logic    rsp_push;
   rsp_type push_data;
   rsp_type head_data;

   nir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nir_decoder u_decoder (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pin_level (req_pin_level),
      .cfg           (cfg),
      .rsp_space     (rsp_space),
      .rsp_push      (rsp_push),
      .rsp_data      (push_data)
   );

   nir_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (push_data),
      .space     (rsp_space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (head_data)
   );

   assign rsp_key_code     = head_data.key_code;
   assign rsp_address_code = head_data.address_code;
   assign rsp_status       = head_data.status;

endmodule
